// ===== rtl/packed_nibble_raster_engine_defines.svh =====
// assertion macros for the packed nibble raster engine
`ifndef PACKED_NIBBLE_RASTER_ENGINE_DEFINES_SVH
`define PACKED_NIBBLE_RASTER_ENGINE_DEFINES_SVH

// same-cycle implication, checked on clock, off during reset
`define PNRE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pnre assertion failed");

// next-cycle implication, checked on clock, off during reset
`define PNRE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pnre assertion failed");

`endif

// ===== rtl/pnre_pkg.sv =====
// shared types and constants of the packed nibble raster engine
package pnre_pkg;

   localparam int MEM_BYTES_DEFAULT = 32768;

   localparam logic [2:0] OP_PIXEL = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_HLINE = 3'd2;
   localparam logic [2:0] OP_VLINE = 3'd3;
   localparam logic [2:0] OP_COPY  = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_MEM   = 2'd2;

   localparam logic [2:0] CSR_DEST_PITCH   = 3'd0;
   localparam logic [2:0] CSR_DEST_WIDTH   = 3'd1;
   localparam logic [2:0] CSR_DEST_HEIGHT  = 3'd2;
   localparam logic [2:0] CSR_XOR_MODE     = 3'd3;
   localparam logic [2:0] CSR_SOURCE_BASE  = 3'd4;
   localparam logic [2:0] CSR_SOURCE_PITCH = 3'd5;
   localparam logic [2:0] CSR_SOURCE_WIDTH = 3'd6;
   localparam logic [2:0] CSR_SOURCE_HEIGHT = 3'd7;

   localparam int CSR_DATA_W = 15;

   localparam logic [9:0]  RST_DEST_PITCH    = 10'd160;
   localparam logic [10:0] RST_DEST_WIDTH    = 11'd320;
   localparam logic [10:0] RST_DEST_HEIGHT   = 11'd200;
   localparam logic        RST_XOR_MODE      = 1'b0;
   localparam logic [14:0] RST_SOURCE_BASE   = 15'd0;
   localparam logic [9:0]  RST_SOURCE_PITCH  = 10'd160;
   localparam logic [10:0] RST_SOURCE_WIDTH  = 11'd320;
   localparam logic [10:0] RST_SOURCE_HEIGHT = 11'd200;

   localparam logic [7:0] LOW_NIBBLE  = 8'h0f;
   localparam logic [7:0] HIGH_NIBBLE = 8'hf0;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [9:0]  pos_x;
      logic [9:0]  pos_y;
      logic [10:0] end_x;
      logic [10:0] end_y;
      logic [3:0]  color;
      logic [9:0]  src_x;
      logic [9:0]  src_y;
      logic [10:0] rect_width;
      logic [10:0] rect_height;
   } req_type;

   typedef struct packed {
      logic [3:0] pixel_value;
      logic [1:0] status;
   } rsp_type;

   // merge a nibble into a byte: replace or xor, even pixel in the high nibble
   function automatic logic [7:0] merge_nibble(input logic [7:0] old_byte,
                                               input logic [3:0] nib,
                                               input logic       odd,
                                               input logic       use_xor);
      logic [7:0] placed;
      logic [7:0] keep;
      placed = odd ? {4'h0, nib} : {nib, 4'h0};
      keep   = odd ? HIGH_NIBBLE : LOW_NIBBLE;
      if (use_xor) begin
         merge_nibble = old_byte ^ placed;
      end else begin
         merge_nibble = (old_byte & keep) | placed;
      end
   endfunction

endpackage

// ===== rtl/pnre_ram.sv =====
// byte memory with one write port and one read port, registered read data
module pnre_ram #(
   parameter int DEPTH = pnre_pkg::MEM_BYTES_DEFAULT,
   parameter int AW    = $clog2(pnre_pkg::MEM_BYTES_DEFAULT)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/packed_nibble_raster_engine.sv =====
// top level of the packed nibble raster engine: command sequencer over a byte memory
//
//   channel | direction | ports                          | moves
//   req     | in        | req_valid req_stall req_payload | one command item
//   rsp     | out       | rsp_valid rsp_stall rsp_payload | one result item per command
//   csr     | in        | csr_write_enable csr_index csr_write_data | register write
//
// one command at a time: range and address checks (S_CALC, S_CHECK), then per pixel
// a dest byte read then write (pixel, lines; a read only reads) or source read, dest read,
// write (copy) on the single memory, then S_FIN posts the result
// empty lines and errors finish after the checks without touching memory
// synchronous active-high reset clears control and config registers; memory is not cleared
// a waiting result sits in its own register, so the next item is taken while it waits
// the finishing step holds while the result register is still full and stalled
`include "packed_nibble_raster_engine_defines.svh"

module packed_nibble_raster_engine #(
   parameter int MEM_BYTES = pnre_pkg::MEM_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pnre_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pnre_pkg::rsp_type               rsp_payload,
   input  logic                            csr_write_enable,
   input  logic [2:0]                      csr_index,
   input  logic [pnre_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int AW = $clog2(MEM_BYTES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CALC  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_SRD   = 3'd3;
   localparam logic [2:0] S_DRD   = 3'd4;
   localparam logic [2:0] S_WR    = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   // configuration registers
   logic [9:0]  dpitch_ff, sp_pitch_ff;
   logic [10:0] dwidth_ff, dheight_ff, swidth_ff, sheight_ff;
   logic        xor_ff;
   logic [14:0] sbase_ff;

   // control
   logic [2:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pnre_pkg::rsp_type rsp_ff, rsp_in;

   // command and derived values
   pnre_pkg::req_type cmd_ff, cmd_in;
   logic        cerr_ff, cerr_in;
   logic        empty_ff, empty_in;
   logic [11:0] dlastx_ff, dlastx_in, slastx_ff, slastx_in;
   logic [21:0] dlastp_ff, dlastp_in, slastp_ff, slastp_in;
   logic [19:0] dfirstp_ff, dfirstp_in, sfirstp_ff, sfirstp_in;
   logic [10:0] nx_ff, nx_in, ny_ff, ny_in;

   // walk
   logic [10:0]   i_ff, i_in, j_ff, j_in;
   logic [AW-1:0] drow_ff, drow_in, srow_ff, srow_in;
   logic [3:0]    snib_ff, snib_in;
   logic [3:0]    value_ff, value_in;
   logic [1:0]    status_ff, status_in;

   // memory port
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]    ram_wr_data, ram_rd_data;

   pnre_ram #(
      .DEPTH (MEM_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         dpitch_ff   <= pnre_pkg::RST_DEST_PITCH;
         dwidth_ff   <= pnre_pkg::RST_DEST_WIDTH;
         dheight_ff  <= pnre_pkg::RST_DEST_HEIGHT;
         xor_ff      <= pnre_pkg::RST_XOR_MODE;
         sbase_ff    <= pnre_pkg::RST_SOURCE_BASE;
         sp_pitch_ff <= pnre_pkg::RST_SOURCE_PITCH;
         swidth_ff   <= pnre_pkg::RST_SOURCE_WIDTH;
         sheight_ff  <= pnre_pkg::RST_SOURCE_HEIGHT;
      end else if (csr_write_enable) begin
         case (csr_index)
            pnre_pkg::CSR_DEST_PITCH:    dpitch_ff   <= csr_write_data[9:0];
            pnre_pkg::CSR_DEST_WIDTH:    dwidth_ff   <= csr_write_data[10:0];
            pnre_pkg::CSR_DEST_HEIGHT:   dheight_ff  <= csr_write_data[10:0];
            pnre_pkg::CSR_XOR_MODE:      xor_ff      <= csr_write_data[0];
            pnre_pkg::CSR_SOURCE_BASE:   sbase_ff    <= csr_write_data[14:0];
            pnre_pkg::CSR_SOURCE_PITCH:  sp_pitch_ff <= csr_write_data[9:0];
            pnre_pkg::CSR_SOURCE_WIDTH:  swidth_ff   <= csr_write_data[10:0];
            pnre_pkg::CSR_SOURCE_HEIGHT: sheight_ff  <= csr_write_data[10:0];
            default: ;
         endcase
      end
   end

   // zero-extended copies of the command coordinates and sizes and of the configured sizes
   logic [11:0] px_e, py_e, ex_e, ey_e, sx_e, sy_e, w_e, h_e;
   logic [11:0] dw_e, dh_e, sw_e, sh_e;
   logic [11:0] dlasty, slasty;
   logic        range_bad;
   logic [22:0] dlast_addr;
   logic [23:0] slast_addr;
   logic        mem_bad;
   logic [10:0] dx, sx;
   logic        last_i, last_j;

   always_comb begin
      px_e = {2'b00, cmd_ff.pos_x};
      py_e = {2'b00, cmd_ff.pos_y};
      ex_e = {1'b0, cmd_ff.end_x};
      ey_e = {1'b0, cmd_ff.end_y};
      sx_e = {2'b00, cmd_ff.src_x};
      sy_e = {2'b00, cmd_ff.src_y};
      w_e  = {1'b0, cmd_ff.rect_width};
      h_e  = {1'b0, cmd_ff.rect_height};
      dw_e = {1'b0, dwidth_ff};
      dh_e = {1'b0, dheight_ff};
      sw_e = {1'b0, swidth_ff};
      sh_e = {1'b0, sheight_ff};

      // coordinate and size checks per opcode
      case (cmd_ff.opcode)
         pnre_pkg::OP_PIXEL, pnre_pkg::OP_READ:
            range_bad = (px_e >= dw_e) || (py_e >= dh_e);
         pnre_pkg::OP_HLINE:
            range_bad = (px_e >= dw_e) || (ex_e > dw_e) || (ex_e < px_e) || (py_e >= dh_e);
         pnre_pkg::OP_VLINE:
            range_bad = (px_e >= dw_e) || (py_e >= dh_e) || (ey_e > dh_e) || (ey_e < py_e);
         pnre_pkg::OP_COPY:
            range_bad = (w_e == 12'd0) || (h_e == 12'd0) || (px_e >= dw_e) ||
                        (py_e >= dh_e) || (sx_e >= sw_e) || (sy_e >= sh_e) ||
                        (px_e + w_e > dw_e) || (py_e + h_e > dh_e) ||
                        (sx_e + w_e > sw_e) || (sy_e + h_e > sh_e);
         default:
            range_bad = 1'b1;
      endcase

      // far corner of what the command touches
      dlastx_in = px_e;
      dlasty    = py_e;
      slastx_in = sx_e + w_e - 12'd1;
      slasty    = sy_e + h_e - 12'd1;
      nx_in     = 11'd1;
      ny_in     = 11'd1;
      case (cmd_ff.opcode)
         pnre_pkg::OP_HLINE: begin
            dlastx_in = ex_e - 12'd1;
            nx_in     = 11'(ex_e - px_e);
         end
         pnre_pkg::OP_VLINE: begin
            dlasty = ey_e - 12'd1;
            ny_in  = 11'(ey_e - py_e);
         end
         pnre_pkg::OP_COPY: begin
            dlastx_in = px_e + w_e - 12'd1;
            dlasty    = py_e + h_e - 12'd1;
            nx_in     = cmd_ff.rect_width;
            ny_in     = cmd_ff.rect_height;
         end
         default: ;
      endcase

      cerr_in    = range_bad;
      empty_in   = ((cmd_ff.opcode == pnre_pkg::OP_HLINE) && (ex_e == px_e)) ||
                   ((cmd_ff.opcode == pnre_pkg::OP_VLINE) && (ey_e == py_e));
      dlastp_in  = 22'(dlasty) * 22'(dpitch_ff);
      slastp_in  = 22'(slasty) * 22'(sp_pitch_ff);
      dfirstp_in = 20'(cmd_ff.pos_y) * 20'(dpitch_ff);
      sfirstp_in = 20'(cmd_ff.src_y) * 20'(sp_pitch_ff);

      // memory bound on the registered products
      dlast_addr = 23'(dlastp_ff) + 23'(dlastx_ff[11:1]);
      slast_addr = 24'(sbase_ff) + 24'(slastx_ff[11:1]) + 24'(slastp_ff);
      mem_bad    = (dlast_addr >= 23'(MEM_BYTES)) ||
                   ((cmd_ff.opcode == pnre_pkg::OP_COPY) && (slast_addr >= 24'(MEM_BYTES)));

      dx     = 11'(cmd_ff.pos_x) + i_ff;
      sx     = 11'(cmd_ff.src_x) + i_ff;
      last_i = (12'(i_ff) + 12'd1 == 12'(nx_ff));
      last_j = (12'(j_ff) + 12'd1 == 12'(ny_ff));
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cmd_in       = cmd_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      drow_in      = drow_ff;
      srow_in      = srow_ff;
      snib_in      = snib_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_addr  = drow_ff + AW'(dx[10:1]);
      ram_rd_addr  = drow_ff + AW'(dx[10:1]);
      ram_wr_data  = pnre_pkg::merge_nibble(ram_rd_data, cmd_ff.color, dx[0], xor_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_payload;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            value_in = 4'd0;
            i_in     = 11'd0;
            j_in     = 11'd0;
            drow_in  = AW'(dfirstp_ff);
            srow_in  = AW'(sbase_ff) + AW'(sfirstp_ff);
            if (cerr_ff) begin
               status_in = pnre_pkg::STATUS_RANGE;
               state_in  = S_FIN;
            end else if (empty_ff) begin
               status_in = pnre_pkg::STATUS_DONE;
               state_in  = S_FIN;
            end else if (mem_bad) begin
               status_in = pnre_pkg::STATUS_MEM;
               state_in  = S_FIN;
            end else begin
               status_in = pnre_pkg::STATUS_DONE;
               state_in  = (cmd_ff.opcode == pnre_pkg::OP_COPY) ? S_SRD : S_DRD;
            end
         end
         S_SRD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = srow_ff + AW'(sx[10:1]);
            state_in    = S_DRD;
         end
         S_DRD: begin
            // source byte lands now for a copy
            snib_in   = sx[0] ? ram_rd_data[3:0] : ram_rd_data[7:4];
            ram_rd_en = 1'b1;
            state_in  = S_WR;
         end
         S_WR: begin
            if (cmd_ff.opcode == pnre_pkg::OP_READ) begin
               value_in = dx[0] ? ram_rd_data[3:0] : ram_rd_data[7:4];
               state_in = S_FIN;
            end else begin
               ram_wr_en = 1'b1;
               if (cmd_ff.opcode == pnre_pkg::OP_COPY) begin
                  ram_wr_data = pnre_pkg::merge_nibble(ram_rd_data, snib_ff, dx[0], 1'b0);
               end
               if (last_i) begin
                  i_in    = 11'd0;
                  j_in    = j_ff + 11'd1;
                  drow_in = drow_ff + AW'(dpitch_ff);
                  srow_in = srow_ff + AW'(sp_pitch_ff);
               end else begin
                  i_in = i_ff + 11'd1;
               end
               if (last_i && last_j) begin
                  state_in = S_FIN;
               end else begin
                  state_in = (cmd_ff.opcode == pnre_pkg::OP_COPY) ? S_SRD : S_DRD;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.pixel_value = value_ff;
               rsp_in.status      = status_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      cmd_ff     <= cmd_in;
      cerr_ff    <= cerr_in;
      empty_ff   <= empty_in;
      dlastx_ff  <= dlastx_in;
      slastx_ff  <= slastx_in;
      dlastp_ff  <= dlastp_in;
      slastp_ff  <= slastp_in;
      dfirstp_ff <= dfirstp_in;
      sfirstp_ff <= sfirstp_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      drow_ff    <= drow_in;
      srow_ff    <= srow_in;
      snib_ff    <= snib_in;
      value_ff   <= value_in;
      status_ff  <= status_in;
   end

   `PNRE_ASSERT_IMP(a_write_only_in_wr, ram_wr_en, state_ff == S_WR)
   `PNRE_ASSERT_IMP(a_no_port_overlap, ram_wr_en, !ram_rd_en)
   `PNRE_ASSERT_NXT(a_accept_to_calc, req_valid && !req_stall, state_ff == S_CALC)
   `PNRE_ASSERT_IMP(a_value_needs_done, rsp_valid && (rsp_payload.pixel_value != 4'd0), rsp_payload.status == pnre_pkg::STATUS_DONE)

endmodule
